@@ design/emazs_pkg.sv @@
// Package with shared types and constants for the EMA z-score divergence marker.
package emazs_pkg;

  localparam int PRICE_BITS_DEF = 24;
  localparam int MAX_WINDOW_DEF = 256;
  localparam int EMA_FRAC       = 16;
  localparam int MARK_BITS      = 12;
  localparam int PERIOD_W       = 13;
  localparam int WINDOW_W       = 9;
  localparam int CFG_DW         = 13;
  localparam int CFG_AW         = 1;
  localparam int OUT_TW         = ((MARK_BITS + 7) / 8) * 8;

  localparam logic [PERIOD_W-1:0]  DEFAULT_PERIOD = PERIOD_W'(50);
  localparam logic [WINDOW_W-1:0]  DEFAULT_WINDOW = WINDOW_W'(100);
  localparam logic [MARK_BITS-1:0] MARKER_FULL    = MARK_BITS'(2560);

  localparam logic [CFG_AW-1:0] REG_EMA_PERIOD = 1'b0;
  localparam logic [CFG_AW-1:0] REG_STD_WINDOW = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_WIN,
    ST_ADD,
    ST_EDIV,
    ST_EUPD,
    ST_MUL_KQ,
    ST_MUL_SS,
    ST_VSUB,
    ST_SQRT,
    ST_AMUL,
    ST_CMP,
    ST_MDIV,
    ST_DONE
  } state_t;

endpackage

@@ design/ema_zscore_divergence_marker_top.sv @@
// Top level: EMA and rolling deviation marker built around one shared subtractor.
// The EMA divide, the square root and the marker divide each work one bit per cycle on the
// shared subtractor, between setup, the multiplies and the hand-off; a first sample skips the
// EMA divide and its update. A new beat is taken only when idle, so no new sample is taken
// before the last one is through; a result waits in the output register meanwhile.
// Synchronous active-low reset clears the EMA, the window counters and sums.
module ema_zscore_divergence_marker_top
  import emazs_pkg::*;
#(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF,
  parameter int PRICE_BITS = PRICE_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [((PRICE_BITS + 7) / 8) * 8-1:0]  in_tdata,   // sample_price
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [OUT_TW-1:0]                      out_tdata,  // marker_size
  input  logic                                   cfg_wr_en,
  input  logic [CFG_AW-1:0]                      cfg_addr,
  input  logic [CFG_DW-1:0]                      cfg_wdata
);

  localparam int PTR_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int TGT_W  = PRICE_BITS + EMA_FRAC;
  localparam int SUM_W  = PRICE_BITS + CNT_W;
  localparam int SQS_W  = 2 * PRICE_BITS + CNT_W;
  localparam int KQ_W   = SQS_W + CNT_W;
  localparam int SQ_IT  = (KQ_W + 1) / 2;
  localparam int BIT_W  = 2 * SQ_IT;
  localparam int R_W    = SQ_IT;
  localparam int A_W    = TGT_W + CNT_W;
  localparam int B_W    = R_W + EMA_FRAC;
  localparam int NM_W   = A_W + MARK_BITS;
  localparam int BS_W   = B_W + MARK_BITS - 1;
  localparam int D_W    = PERIOD_W + 1;
  localparam int NE_W   = TGT_W + 2;
  localparam int SW1    = (BIT_W > NM_W) ? BIT_W : NM_W;
  localparam int SW2    = (SW1 > BS_W) ? SW1 : BS_W;
  localparam int SUB_W  = (SW2 > D_W + 1) ? SW2 : D_W + 1;
  localparam int IT1    = (NE_W > SQ_IT) ? NE_W : SQ_IT;
  localparam int IT_MAX = (IT1 > MARK_BITS) ? IT1 : MARK_BITS;
  localparam int IT_W   = $clog2(IT_MAX + 1);

  state_t               state_r, state_nxt;
  logic [PERIOD_W-1:0]  period_r, period_nxt;
  logic [WINDOW_W-1:0]  window_r, window_nxt;
  logic [PRICE_BITS-1:0] price_r, price_nxt;
  logic [TGT_W-1:0]     ema_r, ema_nxt;
  logic                 seen_r, seen_nxt;
  logic [PTR_W-1:0]     ptr_r, ptr_nxt;
  logic [CNT_W-1:0]     fill_r, fill_nxt;
  logic [SUM_W-1:0]     sum_r, sum_nxt;
  logic [SQS_W-1:0]     sq_r, sq_nxt;
  logic [KQ_W-1:0]      kq_r, kq_nxt;
  logic [KQ_W-1:0]      ss_r, ss_nxt;
  logic [BIT_W-1:0]     root_r, root_nxt;
  logic [BIT_W-1:0]     bit_r, bit_nxt;
  logic [SUB_W-1:0]     acc_r, acc_nxt;
  logic [SUB_W-1:0]     dvs_r, dvs_nxt;
  logic [NE_W-1:0]      quo_r, quo_nxt;
  logic [IT_W-1:0]      cnt_r, cnt_nxt;
  logic [D_W-1:0]       d_r, d_nxt;
  logic                 neg_r, neg_nxt;
  logic [A_W-1:0]       a_r, a_nxt;
  logic [MARK_BITS-1:0] mark_r, mark_nxt;
  logic [MARK_BITS-1:0] out_data_r, out_data_nxt;
  logic                 out_valid_r, out_valid_nxt;

  logic [PRICE_BITS-1:0] ring [MAX_WINDOW];
  logic [PRICE_BITS-1:0] old_r;
  logic                  ring_we, ring_re;
  logic [PTR_W-1:0]      ring_addr;

  logic [SUB_W-1:0]     sub_a, sub_b;
  logic [SUB_W:0]       sub_diff;
  logic                 sub_ge;

  logic [CNT_W-1:0]     m_w;
  logic [PERIOD_W-1:0]  n_w;
  logic [TGT_W-1:0]     target_w;
  logic [TGT_W-1:0]     mag_w;
  logic [PTR_W-1:0]     ptr_eff_w;
  logic [CNT_W:0]       ptr_inc_w;
  logic [2*PRICE_BITS-1:0] old_sq_w, new_sq_w;
  logic [D_W:0]         trial_w;
  logic [B_W-1:0]       b_w;

  always_comb begin
    int unsigned win;
    win = (window_r <= WINDOW_W'(1)) ? 32'(DEFAULT_WINDOW) : 32'(window_r);
    if (win > 32'(MAX_WINDOW)) begin
      win = 32'(MAX_WINDOW);
    end
    m_w = CNT_W'(win);
  end

  assign n_w       = (period_r <= PERIOD_W'(1)) ? DEFAULT_PERIOD : period_r;
  assign target_w  = {price_r, {EMA_FRAC{1'b0}}};
  assign mag_w     = (target_w >= ema_r) ? (target_w - ema_r) : (ema_r - target_w);
  assign ptr_eff_w = ((CNT_W + 1)'(ptr_r) >= (CNT_W + 1)'(m_w)) ? '0 : ptr_r;
  assign ptr_inc_w = (CNT_W + 1)'(ptr_r) + (CNT_W + 1)'(1);
  assign old_sq_w  = old_r * old_r;
  assign new_sq_w  = price_r * price_r;
  assign trial_w   = {acc_r[D_W-1:0], quo_r[NE_W-1]};
  assign b_w       = {root_r[R_W-1:0], {EMA_FRAC{1'b0}}};

  always_comb begin
    sub_a = '0;
    sub_b = '0;
    unique case (state_r)
      ST_EDIV: begin
        sub_a = SUB_W'(trial_w);
        sub_b = SUB_W'(d_r);
      end
      ST_SQRT: begin
        sub_a = acc_r;
        sub_b = SUB_W'(root_r | bit_r);
      end
      ST_CMP: begin
        sub_a = SUB_W'(a_r);
        sub_b = SUB_W'(b_w);
      end
      ST_MDIV: begin
        sub_a = acc_r;
        sub_b = dvs_r;
      end
      default: begin
        sub_a = '0;
        sub_b = '0;
      end
    endcase
  end

  assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_ge   = ~sub_diff[SUB_W];

  always_comb begin
    state_nxt     = state_r;
    period_nxt    = period_r;
    window_nxt    = window_r;
    price_nxt     = price_r;
    ema_nxt       = ema_r;
    seen_nxt      = seen_r;
    ptr_nxt       = ptr_r;
    fill_nxt      = fill_r;
    sum_nxt       = sum_r;
    sq_nxt        = sq_r;
    kq_nxt        = kq_r;
    ss_nxt        = ss_r;
    root_nxt      = root_r;
    bit_nxt       = bit_r;
    acc_nxt       = acc_r;
    dvs_nxt       = dvs_r;
    quo_nxt       = quo_r;
    cnt_nxt       = cnt_r;
    d_nxt         = d_r;
    neg_nxt       = neg_r;
    a_nxt         = a_r;
    mark_nxt      = mark_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;
    ring_we       = 1'b0;
    ring_re       = 1'b0;
    ring_addr     = ptr_r;
    in_tready     = (state_r == ST_IDLE);

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          price_nxt = in_tdata[PRICE_BITS-1:0];
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        ring_re   = 1'b1;
        ring_addr = ptr_eff_w;
        ptr_nxt   = ptr_eff_w;
        d_nxt     = D_W'(n_w) + D_W'(1);
        neg_nxt   = (target_w < ema_r);
        quo_nxt   = NE_W'({mag_w, 1'b0}) + NE_W'(d_nxt >> 1);
        acc_nxt   = '0;
        cnt_nxt   = IT_W'(NE_W);
        if (!seen_r) begin
          ema_nxt = target_w;
        end
        state_nxt = ST_WIN;
      end
      ST_WIN: begin
        if (fill_r >= m_w) begin
          sum_nxt = sum_r - SUM_W'(old_r);
          sq_nxt  = sq_r - SQS_W'(old_sq_w);
        end else begin
          fill_nxt = fill_r + CNT_W'(1);
        end
        state_nxt = ST_ADD;
      end
      ST_ADD: begin
        ring_we   = 1'b1;
        sum_nxt   = sum_r + SUM_W'(price_r);
        sq_nxt    = sq_r + SQS_W'(new_sq_w);
        ptr_nxt   = (ptr_inc_w >= (CNT_W + 1)'(m_w)) ? '0 : ptr_inc_w[PTR_W-1:0];
        seen_nxt  = 1'b1;
        state_nxt = seen_r ? ST_EDIV : ST_MUL_KQ;
      end
      ST_EDIV: begin
        if (sub_ge) begin
          acc_nxt = SUB_W'(sub_diff[D_W-1:0]);
        end else begin
          acc_nxt = SUB_W'(trial_w[D_W-1:0]);
        end
        quo_nxt = {quo_r[NE_W-2:0], sub_ge};
        cnt_nxt = cnt_r - IT_W'(1);
        if (cnt_r == IT_W'(1)) begin
          state_nxt = ST_EUPD;
        end
      end
      ST_EUPD: begin
        ema_nxt   = neg_r ? (ema_r - TGT_W'(quo_r)) : (ema_r + TGT_W'(quo_r));
        state_nxt = ST_MUL_KQ;
      end
      ST_MUL_KQ: begin
        kq_nxt    = KQ_W'(fill_r) * KQ_W'(sq_r);
        state_nxt = ST_MUL_SS;
      end
      ST_MUL_SS: begin
        ss_nxt    = KQ_W'(sum_r) * KQ_W'(sum_r);
        state_nxt = ST_VSUB;
      end
      ST_VSUB: begin
        acc_nxt   = SUB_W'(kq_r - ss_r);
        root_nxt  = '0;
        bit_nxt   = BIT_W'(1) << (BIT_W - 2);
        cnt_nxt   = IT_W'(SQ_IT);
        state_nxt = ST_SQRT;
      end
      ST_SQRT: begin
        if (sub_ge) begin
          acc_nxt  = sub_diff[SUB_W-1:0];
          root_nxt = (root_r >> 1) + bit_r;
        end else begin
          root_nxt = root_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        cnt_nxt = cnt_r - IT_W'(1);
        if (cnt_r == IT_W'(1)) begin
          state_nxt = ST_AMUL;
        end
      end
      ST_AMUL: begin
        a_nxt     = A_W'(mag_w) * A_W'(fill_r);
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        if (root_r == '0) begin
          mark_nxt  = '0;
          state_nxt = ST_DONE;
        end else if (sub_ge) begin
          mark_nxt  = MARKER_FULL;
          state_nxt = ST_DONE;
        end else begin
          acc_nxt   = SUB_W'({a_r, 11'b0}) + SUB_W'({a_r, 9'b0});
          dvs_nxt   = SUB_W'({b_w, {(MARK_BITS - 1){1'b0}}});
          quo_nxt   = '0;
          cnt_nxt   = IT_W'(MARK_BITS);
          state_nxt = ST_MDIV;
        end
      end
      ST_MDIV: begin
        if (sub_ge) begin
          acc_nxt = sub_diff[SUB_W-1:0];
        end
        quo_nxt = {quo_r[NE_W-2:0], sub_ge};
        dvs_nxt = dvs_r >> 1;
        cnt_nxt = cnt_r - IT_W'(1);
        if (cnt_r == IT_W'(1)) begin
          mark_nxt  = {quo_r[MARK_BITS-2:0], sub_ge};
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = mark_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_EMA_PERIOD: begin
          period_nxt = cfg_wdata[PERIOD_W-1:0];
        end
        REG_STD_WINDOW: begin
          window_nxt = cfg_wdata[WINDOW_W-1:0];
          ptr_nxt    = '0;
          fill_nxt   = '0;
          sum_nxt    = '0;
          sq_nxt     = '0;
        end
        default: begin
          period_nxt = period_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      period_r    <= DEFAULT_PERIOD;
      window_r    <= DEFAULT_WINDOW;
      ema_r       <= '0;
      seen_r      <= 1'b0;
      ptr_r       <= '0;
      fill_r      <= '0;
      sum_r       <= '0;
      sq_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      period_r    <= period_nxt;
      window_r    <= window_nxt;
      ema_r       <= ema_nxt;
      seen_r      <= seen_nxt;
      ptr_r       <= ptr_nxt;
      fill_r      <= fill_nxt;
      sum_r       <= sum_nxt;
      sq_r        <= sq_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    price_r    <= price_nxt;
    kq_r       <= kq_nxt;
    ss_r       <= ss_nxt;
    root_r     <= root_nxt;
    bit_r      <= bit_nxt;
    acc_r      <= acc_nxt;
    dvs_r      <= dvs_nxt;
    quo_r      <= quo_nxt;
    cnt_r      <= cnt_nxt;
    d_r        <= d_nxt;
    neg_r      <= neg_nxt;
    a_r        <= a_nxt;
    mark_r     <= mark_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring[ring_addr] <= price_r;
    end
    if (ring_re) begin
      old_r <= ring[ring_addr];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TW'(out_data_r);

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == ST_READ))
    else $error("accepted beat did not start the sequencer");

  a_window_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |->
      ((fill_r <= m_w) && ((CNT_W + 1)'(ptr_r) < (CNT_W + 1)'(m_w))))
    else $error("window count or pointer out of range");

  a_marker_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[MARK_BITS-1:0] <= MARKER_FULL))
    else $error("marker above full scale");

endmodule
